// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies; every other file in src uses this package.
`default_nettype none
package ffba_pkg;

  localparam int LEN_W = 24;
  localparam int START_W = 14;
  localparam int ALLOC_W = 14;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;

  localparam int DEF_NUM_BLOCKS = 16384;
  localparam int DEF_BLOCK_BYTES = 512;

  // free map memory word: 8 blocks per word
  localparam int WORD_BITS = 8;
  localparam int WORD_LG = 3;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                scan_start;
    logic                scan_step;
    logic                mark_free;
    logic                mark_rd;
    logic                mark_wr;
    logic                clr_start;
    logic                clr_step;
    logic                respond;
    logic                use_pos;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              div_done;
    logic              too_large;
    logic              zero_len;
    logic              out_of_range;
    logic              scan_found;
    logic              scan_end;
    logic              mark_last;
    logic              clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
// Depends on ffba_pkg for the command and status structs and codes.
`default_nettype none
module ffba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_MARK_RD = 4'd5;
  localparam logic [3:0] S_MARK_WR = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [ffba_pkg::STATUS_W-1:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      st_r <= ffba_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    cmd = '0;
    cmd.status = st_r;
    cmd.use_pos = (st_r == ffba_pkg::ST_OK) && (sts.mode == ffba_pkg::MODE_ALLOC);
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          st_nxt = ffba_pkg::ST_OK;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_DECIDE;
        else cmd.div_step = 1'b1;
      end
      S_DECIDE: begin
        unique case (sts.mode)
          ffba_pkg::MODE_ALLOC: begin
            if (sts.too_large) begin
              st_nxt = ffba_pkg::ST_TOO_LARGE;
              state_nxt = S_DONE;
            end else if (sts.zero_len) begin
              st_nxt = ffba_pkg::ST_NO_SPACE;
              state_nxt = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          ffba_pkg::MODE_FREE: begin
            if (sts.out_of_range) begin
              st_nxt = ffba_pkg::ST_OUT_OF_RANGE;
              state_nxt = S_DONE;
            end else if (sts.zero_len) begin
              state_nxt = S_DONE;
            end else begin
              cmd.mark_free = 1'b1;
              state_nxt = S_MARK_RD;
            end
          end
          ffba_pkg::MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_nxt = S_CLEAR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_found) begin
          state_nxt = S_MARK_RD;
        end else if (sts.scan_end) begin
          st_nxt = ffba_pkg::ST_NO_SPACE;
          state_nxt = S_DONE;
        end
      end
      S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_nxt = sts.mark_last ? S_DONE : S_MARK_RD;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ffba_dp.sv =====
// Datapath of the first-fit block allocator: free map memory, block-count
// reciprocal multiply, first-fit scanner, range marker and result registers. Uses ffba_pkg.
`default_nettype none
module ffba_dp #(
  parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = ffba_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ffba_pkg::cmd_t                 cmd,
  output ffba_pkg::sts_t                      sts,
  input  wire logic [ffba_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [ffba_pkg::LEN_W-1:0]     in_length_bytes,
  input  wire logic [ffba_pkg::START_W-1:0]   in_start_block,
  output logic                                out_valid,
  output logic [ffba_pkg::ALLOC_W-1:0]        out_alloc_start,
  output logic [ffba_pkg::STATUS_W-1:0]       out_status
);

  localparam int WB = ffba_pkg::WORD_BITS;
  localparam int WL = ffba_pkg::WORD_LG;
  localparam int NWORDS = (NUM_BLOCKS + WB - 1) / WB;
  localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IW = AW + WL + 1;
  localparam int NW = ffba_pkg::LEN_W + 1;
  localparam int LG_B = $clog2(BLOCK_BYTES);
  localparam int KSH = NW + LG_B;
  localparam int PW = 2 * NW + 1;
  // exact for every numerator below 2**NW
  localparam longint RECIP = ((longint'(1) << KSH) + longint'(BLOCK_BYTES) - 1) /
                             longint'(BLOCK_BYTES);
  localparam longint TOTAL_BYTES = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  // free map, 1 = free
  logic [WB-1:0] mem [NWORDS];
  logic [WB-1:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic [WB-1:0] wdata;
  logic          we;

  // captured request
  logic [ffba_pkg::MODE_W-1:0]  mode_r;
  logic [ffba_pkg::LEN_W-1:0]   len_r;
  logic [ffba_pkg::START_W-1:0] first_r;

  // block count
  logic [NW-1:0] dq_r;
  logic          q_ok_r;
  logic [PW-1:0] prod;

  // scanner
  logic [AW-1:0] s_addr_r, sw_r;
  logic          s_more_r, sv_r;
  logic [IW-1:0] run_r, run_nxt, need, hit_pos;
  logic          hit;

  // marker
  logic [IW-1:0] lo_r, hi_r, pos_r, hi_m1;
  logic [AW-1:0] m_addr_r;
  logic          set_r;
  logic [WB-1:0] mark_word;

  logic [AW-1:0] c_addr_r;

  logic [ffba_pkg::STATUS_W-1:0] out_status_r;
  logic [ffba_pkg::ALLOC_W-1:0]  out_alloc_r;
  logic                          out_valid_r;
  logic [31:0]                   pos_ext;
  logic [NW:0]                   free_end;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign raddr = cmd.mark_rd ? m_addr_r : s_addr_r;
  assign we = cmd.clr_step | cmd.mark_wr;
  assign waddr = cmd.clr_step ? c_addr_r : m_addr_r;
  assign wdata = cmd.clr_step ? {WB{1'b1}} : mark_word;

  // ceil(len / BLOCK_BYTES) as (len + BLOCK_BYTES - 1) times a fixed reciprocal
  assign prod = PW'(dq_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      len_r <= in_length_bytes;
      first_r <= in_start_block;
      dq_r <= NW'(in_length_bytes) + NW'(BLOCK_BYTES - 1);
    end else if (cmd.div_step) begin
      dq_r <= NW'(prod >> KSH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_ok_r <= 1'b0;
    else if (cmd.load) q_ok_r <= 1'b0;
    else if (cmd.div_step) q_ok_r <= 1'b1;
  end

  assign need = IW'(dq_r);
  assign free_end = (NW+1)'(first_r) + (NW+1)'(dq_r);

  // scan: walk bits of one word, counting the current free run
  always_comb begin
    logic [IW-1:0] g;
    logic          fr;
    run_nxt = run_r;
    hit = 1'b0;
    hit_pos = '0;
    for (int b = 0; b < WB; b++) begin
      g = IW'({sw_r, WL'(b)});
      fr = rdata_r[b] && (g < IW'(NUM_BLOCKS));
      if (!hit) begin
        if (fr) begin
          run_nxt = run_nxt + 1'b1;
          if (run_nxt == need) begin
            hit = 1'b1;
            hit_pos = g + 1'b1 - need;
          end
        end else begin
          run_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_more_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (cmd.scan_start) begin
      s_more_r <= 1'b1;
      sv_r <= 1'b0;
    end else if (cmd.scan_step) begin
      sv_r <= s_more_r;
      if (s_more_r && s_addr_r == LAST_WORD) s_more_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      s_addr_r <= '0;
      run_r <= '0;
    end else if (cmd.scan_step) begin
      if (s_more_r) begin
        sw_r <= s_addr_r;
        s_addr_r <= s_addr_r + 1'b1;
      end
      if (sv_r) run_r <= run_nxt;
    end
  end

  // marker: read-modify-write each word that the range touches
  assign hi_m1 = hi_r - 1'b1;

  always_comb begin
    logic [IW-1:0] g;
    for (int b = 0; b < WB; b++) begin
      g = IW'({m_addr_r, WL'(b)});
      mark_word[b] = (g >= lo_r && g < hi_r) ? set_r : rdata_r[b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && sv_r && hit) begin
      pos_r <= hit_pos;
      lo_r <= hit_pos;
      hi_r <= hit_pos + need;
      m_addr_r <= hit_pos[IW-2:WL];
      set_r <= 1'b0;
    end else if (cmd.mark_free) begin
      lo_r <= IW'(first_r);
      hi_r <= IW'(first_r) + need;
      m_addr_r <= AW'(first_r >> WL);
      set_r <= 1'b1;
    end else if (cmd.mark_wr) begin
      m_addr_r <= m_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) c_addr_r <= '0;
    else if (cmd.clr_step) c_addr_r <= c_addr_r + 1'b1;
  end

  assign pos_ext = 32'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.respond;
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_status_r <= cmd.status;
      out_alloc_r <= cmd.use_pos ? pos_ext[ffba_pkg::ALLOC_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_alloc_start = out_alloc_r;

  always_comb begin
    sts.mode = mode_r;
    sts.div_done = q_ok_r;
    sts.too_large = (64'(len_r) > 64'(TOTAL_BYTES));
    sts.zero_len = (len_r == '0);
    sts.out_of_range = (free_end > (NW+1)'(NUM_BLOCKS));
    sts.scan_found = sv_r && hit;
    sts.scan_end = sv_r && !hit && (sw_r == LAST_WORD);
    sts.mark_last = (m_addr_r == hi_m1[IW-2:WL]);
    sts.clr_last = (c_addr_r == LAST_WORD);
  end

endmodule
`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
// A command beat is taken when start is high and busy is low; every command
// gives exactly one result beat, shown on the out_ ports for one cycle with
// out_valid high, and the receiver cannot hold it off. Each command first
// computes its block count with a reciprocal multiply and then decides what
// to do.
// An allocate then streams the free map, 8 blocks per memory word, one word a
// cycle from word 0 until a run is found or the last word is read, and marks
// the run with a read state and a write state per touched word; a free marks
// its range the same way. After reset, and on every clear-all, a sweep writes
// all NUM_BLOCKS/8 map words free; busy stays high during the sweep. The free
// map memory, with one read and one write port, bounds the rate.
`default_nettype none
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = ffba_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ffba_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [ffba_pkg::LEN_W-1:0]     in_length_bytes,
  input  wire logic [ffba_pkg::START_W-1:0]   in_start_block,
  output logic                                out_valid,
  output logic [ffba_pkg::ALLOC_W-1:0]        out_alloc_start,
  output logic [ffba_pkg::STATUS_W-1:0]       out_status
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  // sequence the command: divide, decide, scan, mark or sweep, then respond
  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // hold the map and do the arithmetic
  ffba_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_length_bytes (in_length_bytes),
    .in_start_block  (in_start_block),
    .out_valid       (out_valid),
    .out_alloc_start (out_alloc_start),
    .out_status      (out_status)
  );

  // a result beat lasts exactly one cycle
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat longer than one cycle");

  // an accepted command makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command accepted but not busy");

  // a result is only shown once the block is ready again
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // failed commands report start block zero
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffba_pkg::ST_OK) |-> (out_alloc_start == '0))
    else $error("nonzero start on failed command");

endmodule
`default_nettype wire
